/* hdl/iee_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

  // character codes the parser reacts to
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned RESULT_WIDTH = 64;

  // parser position within the grammar
  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0,
    PH_SIGN   = 2'd1,
    PH_NUMBER = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // operator waiting for the next number of the current term
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic unit_write;
    logic after_op;
    logic fold_end;
    logic end_fail;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_commit;
    logic commit_unit;
    logic unit_done;
    logic phase_number;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

/* hdl/iee_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// character item channel
interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// result item channel
interface iee_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic               error_flag;

  modport source (output valid, output result_value, output error_flag, input ready);
  modport sink   (input valid, input result_value, input error_flag, output ready);
endinterface

`default_nettype wire

/* hdl/infix_expression_evaluator_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  payload                      handshake
// char_in_i  in         char_code[7:0], last_char    valid / ready
// res_out_o  out        result_value[63:0], error_flag  valid / ready
//
// Each item passes S_IDLE, S_DECODE and S_LAST; an item that ends a number
// also passes S_COMMIT and S_AFTER, with S_WAIT between them when that number
// closes a '*' or '/' on the shared shift-add / restoring divide unit.
// A final item inside a number then closes it and folds the term; every
// final item loads the output register in S_OUT. Items are taken only in S_IDLE.
// Reset clears the parser, so the first item starts a fresh expression.
// The result waits in an output register; a full register stalls only the
// next final item, not the characters before it.

module infix_expression_evaluator_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  iee_char_if.sink          char_in_i,
  iee_result_if.source      res_out_o
);

  iee_pkg::cmd_t cmd;
  iee_pkg::sts_t sts;

  iee_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(char_in_i.valid),
    .in_ready_o(char_in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  iee_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .char_code_i   (char_in_i.char_code),
    .last_char_i   (char_in_i.last_char),
    .out_ready_i   (res_out_o.ready),
    .out_valid_o   (res_out_o.valid),
    .result_value_o(res_out_o.result_value),
    .error_flag_o  (res_out_o.error_flag)
  );

endmodule

`default_nettype wire

/* hdl/iee_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

module iee_muldiv #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   div_i,
  input  wire logic [VALUE_WIDTH-1:0] a_i,
  input  wire logic [VALUE_WIDTH-1:0] b_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      res_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          div_q, div_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  y_q, y_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  res_q, res_d;
  logic [W:0]    trial;
  logic [W-1:0]  a_mag, b_mag;

  assign a_mag = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign b_mag = b_i[W-1] ? (W'(0) - b_i) : b_i;
  // restoring division trial subtract
  assign trial = {acc_q, x_q[W-1]} - {1'b0, y_q};

  // one shift-add or one restoring step per cycle, then a result write that sign-fixes a quotient
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = div_i;
      neg_d  = a_i[W-1] ^ b_i[W-1];
      x_d    = div_i ? a_mag : a_i;
      y_d    = div_i ? b_mag : b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(W)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = div_q ? (neg_q ? (W'(0) - x_q) : x_q) : acc_q;
      end else begin
        cnt_d = cnt_q + CW'(1);
        if (div_q) begin
          if (!trial[W]) begin
            acc_d = trial[W-1:0];
            x_d   = {x_q[W-2:0], 1'b1};
          end else begin
            acc_d = {acc_q[W-2:0], x_q[W-1]};
            x_d   = {x_q[W-2:0], 1'b0};
          end
        end else begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[W-2:0], 1'b0};
          y_d = {1'b0, y_q[W-1:1]};
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* hdl/iee_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module iee_datapath #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire iee_pkg::cmd_t        cmd_i,
  output iee_pkg::sts_t             sts_o,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 last_char_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic signed [63:0]        result_value_o,
  output logic                      error_flag_o
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [7:0]        char_q;
  logic              last_q;
  iee_pkg::phase_e   phase_q, phase_d;
  logic [W-1:0]      sum_q, sum_d;
  logic              sub_q, sub_d;
  logic [W-1:0]      term_q, term_d;
  iee_pkg::term_op_e top_q, top_d;
  logic [W-1:0]      num_q, num_d;
  logic              neg_q, neg_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       res_q, res_d;
  logic              res_err_q, res_err_d;

  logic              blank, digit;
  logic [7:0]        digit_val;
  logic [W-1:0]      digit_w;
  logic [W-1:0]      num_value;
  logic [W-1:0]      sum_fold;
  logic              commit_unit;
  logic              unit_start;
  logic              unit_done;
  logic [W-1:0]      unit_res;

  // character classes and number value
  assign blank     = iee_pkg::is_blank(char_q);
  assign digit     = iee_pkg::is_digit(char_q);
  assign digit_val = char_q - iee_pkg::CH_ZERO;
  assign digit_w   = W'(digit_val);
  assign num_value = neg_q ? (W'(0) - num_q) : num_q;
  assign sum_fold  = sub_q ? (sum_q - term_q) : (sum_q + term_q);
  assign commit_unit = (top_q == iee_pkg::OP_MUL) ||
                       ((top_q == iee_pkg::OP_DIV) && (num_value != '0));
  assign unit_start  = cmd_i.commit && commit_unit;

  iee_muldiv #(
    .VALUE_WIDTH(W)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(unit_start),
    .div_i  (top_q == iee_pkg::OP_DIV),
    .a_i    (term_q),
    .b_i    (num_value),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  // parser state updates
  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    sub_d       = sub_q;
    term_d      = term_q;
    top_d       = top_q;
    num_d       = num_q;
    neg_d       = neg_q;
    err_d       = err_q;
    res_d       = res_q;
    res_err_d   = res_err_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    // plain character step
    if (cmd_i.step && !blank && (phase_q != iee_pkg::PH_DONE)) begin
      case (phase_q)
        iee_pkg::PH_EXPECT: begin
          if (char_q == iee_pkg::CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = iee_pkg::PH_SIGN;
          end else if (digit) begin
            num_d   = digit_w;
            phase_d = iee_pkg::PH_NUMBER;
          end else begin
            err_d   = 1'b1;
            phase_d = iee_pkg::PH_DONE;
          end
        end
        iee_pkg::PH_SIGN: begin
          if (digit) begin
            num_d   = digit_w;
            phase_d = iee_pkg::PH_NUMBER;
          end else begin
            err_d   = 1'b1;
            phase_d = iee_pkg::PH_DONE;
          end
        end
        iee_pkg::PH_NUMBER: begin
          if (digit) begin
            num_d = (num_q << 3) + (num_q << 1) + digit_w;
          end
        end
        default: begin
        end
      endcase
    end

    // close the number into the current term
    if (cmd_i.commit) begin
      if (!commit_unit) begin
        if (top_q == iee_pkg::OP_DIV) begin
          err_d   = 1'b1;
          phase_d = iee_pkg::PH_DONE;
        end else begin
          term_d = num_value;
        end
      end
      top_d = iee_pkg::OP_NONE;
      num_d = '0;
      neg_d = 1'b0;
    end

    if (cmd_i.unit_write) begin
      term_d = unit_res;
    end

    // operator or other character that ended a number
    if (cmd_i.after_op && !err_q) begin
      if ((char_q == iee_pkg::CH_PLUS) || (char_q == iee_pkg::CH_MINUS)) begin
        sum_d   = sum_fold;
        term_d  = '0;
        sub_d   = (char_q == iee_pkg::CH_MINUS);
        phase_d = iee_pkg::PH_EXPECT;
      end else if ((char_q == iee_pkg::CH_STAR) || (char_q == iee_pkg::CH_SLASH)) begin
        top_d   = (char_q == iee_pkg::CH_STAR) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
        phase_d = iee_pkg::PH_EXPECT;
      end else begin
        sum_d   = sum_fold;
        term_d  = '0;
        sub_d   = 1'b0;
        phase_d = iee_pkg::PH_DONE;
      end
    end

    if (cmd_i.fold_end && !err_q) begin
      sum_d  = sum_fold;
      term_d = '0;
      sub_d  = 1'b0;
    end

    // expression ended outside a number
    if (cmd_i.end_fail && (phase_q != iee_pkg::PH_DONE)) begin
      err_d   = 1'b1;
      phase_d = iee_pkg::PH_DONE;
    end

    // hand the value over and start afresh
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      res_err_d   = err_q;
      res_d       = err_q ? '0 : iee_pkg::RESULT_WIDTH'(signed'(sum_q));
      phase_d     = iee_pkg::PH_EXPECT;
      sum_d       = '0;
      sub_d       = 1'b0;
      term_d      = '0;
      top_d       = iee_pkg::OP_NONE;
      num_d       = '0;
      neg_d       = 1'b0;
      err_d       = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= iee_pkg::PH_EXPECT;
      sum_q       <= '0;
      sub_q       <= 1'b0;
      term_q      <= '0;
      top_q       <= iee_pkg::OP_NONE;
      num_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      sub_q       <= sub_d;
      term_q      <= term_d;
      top_q       <= top_d;
      num_q       <= num_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured item and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    res_q     <= res_d;
    res_err_q <= res_err_d;
  end

  assign sts_o.need_commit  = (phase_q == iee_pkg::PH_NUMBER) && !blank && !digit;
  assign sts_o.commit_unit  = commit_unit;
  assign sts_o.unit_done    = unit_done;
  assign sts_o.phase_number = (phase_q == iee_pkg::PH_NUMBER);
  assign sts_o.last         = last_q;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign error_flag_o   = res_err_q;

endmodule

`default_nettype wire

/* hdl/iee_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module iee_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire iee_pkg::sts_t sts_i,
  output iee_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_COMMIT = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_AFTER  = 7'b0010000,
    S_LAST   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  // sequencing of one item
  always_comb begin
    state_d    = state_q;
    flush_d    = flush_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.need_commit) begin
          flush_d = 1'b0;
          state_d = S_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_LAST;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.commit_unit ? S_WAIT : S_AFTER;
      end
      S_WAIT: begin
        if (sts_i.unit_done) begin
          cmd_o.unit_write = 1'b1;
          state_d          = S_AFTER;
        end
      end
      S_AFTER: begin
        if (flush_q) begin
          cmd_o.fold_end = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.after_op = 1'b1;
          state_d        = S_LAST;
        end
      end
      S_LAST: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.phase_number) begin
          flush_d = 1'b1;
          state_d = S_COMMIT;
        end else begin
          cmd_o.end_fail = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

endmodule

`default_nettype wire

/* dv/iee_expr_checker.sv */
`timescale 1ns / 1ps

module iee_expr_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  iee_char_if    char_mon_i,
  iee_result_if  res_mon_i,
  output int     mismatch_count_o,
  output int     pending_o
);

  // one predicted result item
  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } outcome_t;

  outcome_t expected_values[$];

  // shadow of the parser and its accumulators
  iee_pkg::phase_e   parse_q;
  iee_pkg::term_op_e op_q;
  logic [63:0] sum_q;
  logic [63:0] term_q;
  logic [63:0] mag_q;
  logic        sub_q;
  logic        neg_q;
  logic        err_q;

  task automatic clear_state();
    parse_q = iee_pkg::PH_EXPECT;
    op_q    = iee_pkg::OP_NONE;
    sum_q   = '0;
    term_q  = '0;
    mag_q   = '0;
    sub_q   = 1'b0;
    neg_q   = 1'b0;
    err_q   = 1'b0;
  endtask

  task automatic flag_error();
    err_q   = 1'b1;
    parse_q = iee_pkg::PH_DONE;
  endtask

  // signed quotient, truncated toward zero
  function automatic logic [63:0] quotient_trunc(input logic [63:0] num,
                                                 input logic [63:0] den);
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [63:0] q;
    num_mag = num[63] ? -num : num;
    den_mag = den[63] ? -den : den;
    q = num_mag / den_mag;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  // apply the finished number to the current term
  task automatic take_number();
    logic [63:0] operand;
    operand = neg_q ? -mag_q : mag_q;
    if (op_q == iee_pkg::OP_MUL) begin
      term_q = term_q * operand;
    end else if (op_q == iee_pkg::OP_DIV) begin
      if (operand == '0) begin
        flag_error();
      end else begin
        term_q = quotient_trunc(term_q, operand);
      end
    end else begin
      term_q = operand;
    end
    op_q  = iee_pkg::OP_NONE;
    mag_q = '0;
    neg_q = 1'b0;
  endtask

  // add or subtract the finished term
  task automatic fold_term();
    sum_q  = sub_q ? sum_q - term_q : sum_q + term_q;
    term_q = '0;
    sub_q  = 1'b0;
  endtask

  task automatic eval_char(input logic [7:0] c, input logic last);
    logic     digit;
    logic     blank;
    outcome_t res;
    digit = (c >= iee_pkg::CH_ZERO) && (c <= iee_pkg::CH_NINE);
    blank = (c == iee_pkg::CH_SPACE) || ((c >= iee_pkg::CH_TAB) && (c <= iee_pkg::CH_CR));
    if (!blank && parse_q != iee_pkg::PH_DONE) begin
      case (parse_q)
        iee_pkg::PH_EXPECT: begin
          if (c == iee_pkg::CH_MINUS) begin
            neg_q   = 1'b1;
            parse_q = iee_pkg::PH_SIGN;
          end else if (digit) begin
            mag_q   = 64'(c - iee_pkg::CH_ZERO);
            parse_q = iee_pkg::PH_NUMBER;
          end else begin
            flag_error();
          end
        end
        iee_pkg::PH_SIGN: begin
          if (digit) begin
            mag_q   = 64'(c - iee_pkg::CH_ZERO);
            parse_q = iee_pkg::PH_NUMBER;
          end else begin
            flag_error();
          end
        end
        default: begin
          if (digit) begin
            mag_q = mag_q * 10 + 64'(c - iee_pkg::CH_ZERO);
          end else begin
            take_number();
            if (!err_q) begin
              if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS) begin
                fold_term();
                sub_q   = (c == iee_pkg::CH_MINUS);
                parse_q = iee_pkg::PH_EXPECT;
              end else if (c == iee_pkg::CH_STAR) begin
                op_q    = iee_pkg::OP_MUL;
                parse_q = iee_pkg::PH_EXPECT;
              end else if (c == iee_pkg::CH_SLASH) begin
                op_q    = iee_pkg::OP_DIV;
                parse_q = iee_pkg::PH_EXPECT;
              end else begin
                // any other character closes the expression
                fold_term();
                parse_q = iee_pkg::PH_DONE;
              end
            end
          end
        end
      endcase
    end
    if (last) begin
      if (parse_q == iee_pkg::PH_NUMBER) begin
        take_number();
        if (!err_q) begin
          fold_term();
        end
      end else if (parse_q != iee_pkg::PH_DONE) begin
        flag_error();
      end
      res.error = err_q;
      res.value = err_q ? '0 : sum_q;
      expected_values.push_back(res);
      clear_state();
    end
  endtask

  // compare results, then advance the model on accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      clear_state();
      expected_values.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (expected_values.size() == 0) begin
          $error("result item with none expected: result_value %0d error_flag %0b",
                 res_mon_i.result_value, res_mon_i.error_flag);
          mismatch_count_o++;
        end else begin
          want = expected_values.pop_front();
          if (res_mon_i.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.value), res_mon_i.result_value);
            mismatch_count_o++;
          end
          if (res_mon_i.error_flag !== want.error) begin
            $error("error_flag: expected %0b, got %0b", want.error, res_mon_i.error_flag);
            mismatch_count_o++;
          end
        end
      end
      if (char_mon_i.valid && char_mon_i.ready) begin
        eval_char(char_mon_i.char_code, char_mon_i.last_char);
      end
      pending_o <= expected_values.size();
    end
  end

endmodule

/* dv/tb_infix_expression_evaluator_core.sv */
`timescale 1ns / 1ps

module tb_infix_expression_evaluator_core;

  localparam int unsigned STALL_LIMIT  = 10000;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned RANDOM_ITEMS = 630;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  iee_char_if   char_bus ();
  iee_result_if res_bus ();

  int         mismatches;
  int         pending;
  int         items_sent;
  int         src_idle_pct;
  int         sink_stall_pct;
  logic       hold_go;
  int         hold_count = 0;
  int         quiet_cycles = 0;
  logic [7:0] expr_text[$];

  always #10 clk_i = ~clk_i;

  infix_expression_evaluator_core #(
    .VALUE_WIDTH (64)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_in_i (char_bus),
    .res_out_o (res_bus)
  );

  iee_expr_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_mon_i       (char_bus),
    .res_mon_i        (res_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // result side: random stalls, plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (hold_go && hold_count < HOLD_CYCLES) begin
      res_bus.ready <= 1'b0;
      hold_count = hold_count + 1;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_text.push_back(s[i]);
    end
  endtask

  // now and then a whitespace character
  task automatic push_blank();
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(5) == 0) begin
        expr_text.push_back(iee_pkg::CH_SPACE);
      end else begin
        expr_text.push_back(8'(iee_pkg::CH_TAB + $urandom_range(4)));
      end
    end
  endtask

  task automatic push_number(input int digits, input logic minus);
    if (minus) begin
      expr_text.push_back(iee_pkg::CH_MINUS);
      push_blank();
    end
    for (int i = 0; i < digits; i++) begin
      expr_text.push_back(8'(iee_pkg::CH_ZERO + $urandom_range(9)));
      if (i != digits - 1) begin
        push_blank();
      end
    end
  endtask

  // mostly short numbers, a few long enough to wrap
  function automatic int pick_digits();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      return $urandom_range(1, 2);
    end else if (roll < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(15, 22);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0:       return iee_pkg::CH_PLUS;
      1:       return iee_pkg::CH_MINUS;
      2:       return iee_pkg::CH_STAR;
      default: return iee_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic make_expression();
    int kind;
    int terms;
    kind = $urandom_range(99);
    expr_text.delete();
    if (kind < 4) begin
      // most negative value over minus one, sometimes then a wrapping product
      push_text("-9223372036854775808/-1");
      if ($urandom_range(1) == 1) begin
        push_text("*-1+1");
      end
    end else if (kind < 6) begin
      // whitespace only
      repeat ($urandom_range(1, 3)) expr_text.push_back(iee_pkg::CH_SPACE);
    end else begin
      terms = $urandom_range(1, 6);
      push_blank();
      for (int t = 0; t < terms; t++) begin
        if (t > 0) begin
          push_blank();
          expr_text.push_back(pick_op());
          push_blank();
        end
        push_number(pick_digits(), $urandom_range(3) == 0);
      end
      push_blank();
      if (kind >= 93) begin
        // random byte as a possible early terminator, followed by random noise
        expr_text.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(1, 5)) expr_text.push_back(8'($urandom_range(255)));
      end else if (kind >= 88) begin
        // dangling operator or sign
        expr_text.push_back(($urandom_range(2) == 0) ? pick_op() : iee_pkg::CH_MINUS);
        if ($urandom_range(1) == 1) begin
          expr_text.push_back(iee_pkg::CH_MINUS);
        end
      end else if (kind >= 82) begin
        // stray byte anywhere
        expr_text.insert($urandom_range(expr_text.size()), 8'($urandom_range(255)));
      end
    end
  endtask

  // offer each character, last one flagged
  task automatic send_expression();
    for (int i = 0; i < expr_text.size(); i++) begin
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        char_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
      char_bus.valid     <= 1'b1;
      char_bus.char_code <= expr_text[i];
      char_bus.last_char <= (i == expr_text.size() - 1);
      @(posedge clk_i);
      while (char_bus.ready !== 1'b1) @(posedge clk_i);
    end
    items_sent += expr_text.size();
  endtask

  initial begin
    int expr_count;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.last_char <= 1'b0;
    hold_go            <= 1'b0;
    sink_stall_pct     <= 0;
    src_idle_pct        = 0;
    items_sent          = 0;
    expr_count          = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all operators, a joined number and a negative divisor
    expr_text.delete();
    push_text("1 2+2*3-8/-3");
    send_expression();
    // missing number on an all-ones byte
    expr_text.delete();
    expr_text.push_back(8'hFF);
    send_expression();
    // division by zero
    expr_text.delete();
    push_text("5/0");
    send_expression();
    // an all-zeros byte ends parsing, the digit after it is ignored
    expr_text.delete();
    push_text("4");
    expr_text.push_back(8'h00);
    push_text("9");
    send_expression();
    // blank expression
    expr_text.delete();
    push_text(" ");
    send_expression();
    // operator with nothing after it
    expr_text.delete();
    push_text("7-");
    send_expression();

    // random part; the receiver holds off at the start to fill the block
    hold_go <= 1'b1;
    while (items_sent < RANDOM_ITEMS + 22) begin
      case ((expr_count / 8) % 4)
        0: begin
          src_idle_pct    = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct    = 59;
          sink_stall_pct <= 0;
        end
        2: begin
          src_idle_pct    = 0;
          sink_stall_pct <= 59;
        end
        default: begin
          src_idle_pct    = 11;
          sink_stall_pct <= 11;
        end
      endcase
      make_expression();
      send_expression();
      expr_count++;
    end
    char_bus.valid <= 1'b0;

    // let outstanding results come back
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* infix_expression_evaluator_core.f */
hdl/iee_pkg.sv
hdl/iee_if.sv
hdl/iee_muldiv.sv
hdl/iee_datapath.sv
hdl/iee_ctrl.sv
hdl/infix_expression_evaluator_core.sv
dv/iee_expr_checker.sv
dv/tb_infix_expression_evaluator_core.sv
